/* design/qalu_pkg.sv */
package qalu_pkg;

  localparam int CompWidth = 32;
  localparam int FracBits  = 16;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_SCALE = 4'd3,
    OP_CONJ  = 4'd4,
    OP_NORM  = 4'd5,
    OP_INV   = 4'd6,
    OP_MAG   = 4'd7,
    OP_MAG2  = 4'd8
  } op_e;

  typedef struct packed {
    logic        [3:0]           opcode;
    logic signed [CompWidth-1:0] a_w;
    logic signed [CompWidth-1:0] a_x;
    logic signed [CompWidth-1:0] a_y;
    logic signed [CompWidth-1:0] a_z;
    logic signed [CompWidth-1:0] b_w;
    logic signed [CompWidth-1:0] b_x;
    logic signed [CompWidth-1:0] b_y;
    logic signed [CompWidth-1:0] b_z;
    logic signed [CompWidth-1:0] scale_factor;
  } qalu_req_t;

  typedef struct packed {
    logic signed [CompWidth-1:0] r_w;
    logic signed [CompWidth-1:0] r_x;
    logic signed [CompWidth-1:0] r_y;
    logic signed [CompWidth-1:0] r_z;
    logic                        range_flag;
  } qalu_rsp_t;

  // Hamilton product: result component k is the signed sum over j of
  // a[MulAIdx[k][j]] * b[MulBIdx[k][j]], negated where MulNeg[k][j] is set.
  localparam logic [1:0] MulAIdx [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd2, 2'd3, 2'd1},
    '{2'd0, 2'd3, 2'd1, 2'd2}
  };
  localparam logic [1:0] MulBIdx [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd2, 2'd1}
  };
  localparam logic MulNeg [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1}
  };

endpackage

/* design/qalu_div.sv */
module qalu_div import qalu_pkg::*; #(
  parameter int NumW = CompWidth + 2 * FracBits,
  parameter int DenW = 2 * CompWidth + 1
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [NumW:0]   quo_o
);

  // One quotient bit per stage, restoring division, then a rounding stage.
  logic [NumW-1:0] n_q   [NumW];
  logic [DenW-1:0] d_q   [NumW+1];
  logic [DenW-1:0] rem_q [NumW+1];
  logic [NumW-1:0] q_q   [NumW+1];
  logic [NumW:0]   quo_q;
  logic            rnd_up;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]   <= num_i;
      d_q[0]   <= den_i;
      rem_q[0] <= '0;
      q_q[0]   <= '0;
    end
  end

  for (genvar j = 0; j < NumW; j++) begin : g_step
    logic [DenW:0] rem2;
    logic [DenW:0] diff;
    logic          ge;

    assign rem2 = {rem_q[j], n_q[j][NumW-1]};
    assign ge   = rem2 >= {1'b0, d_q[j]};
    assign diff = rem2 - {1'b0, d_q[j]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[j+1]   <= d_q[j];
        rem_q[j+1] <= ge ? diff[DenW-1:0] : rem2[DenW-1:0];
        q_q[j+1]   <= {q_q[j][NumW-2:0], ge};
      end
    end

    if (j < NumW - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          n_q[j+1] <= n_q[j] << 1;
        end
      end
    end
  end

  // Round to nearest with ties up: compare twice the remainder with the divisor.
  assign rnd_up = {rem_q[NumW], 1'b0} >= {1'b0, d_q[NumW]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= {1'b0, q_q[NumW]} + (NumW+1)'(rnd_up);
    end
  end

  assign quo_o = quo_q;

endmodule

/* design/quaternion_alu.sv */
// Channel   Direction  Handshake                   Payload
// request   in         in_valid_i / in_ready_o     in_req_i  (qalu_req_t)
// result    out        out_valid_o / out_ready_i   out_rsp_o (qalu_rsp_t)
//
// One request is taken per cycle while in_ready_o is high. The pipeline depth is set
// by the square root (one root bit per stage) followed by the dividers (one quotient bit
// per stage). Reset clears only the valid bits of the stages. When the result is not
// taken, the whole pipeline holds in place and in_ready_o drops.
module quaternion_alu import qalu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  qalu_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output qalu_rsp_t out_rsp_o
);

  localparam int W      = CompWidth;
  localparam int F      = FracBits;
  localparam int PW     = 2 * W;
  localparam int SW     = 2 * W + 2;
  localparam int QW     = 2 * W + 1;
  localparam int RootW  = W + 1;
  localparam int RemW   = W + 4;
  localparam int NW     = W + 2 * F;
  localparam int DivLat = NW + 2;

  localparam logic [W-1:0]  MaxVal  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MinVal  = {1'b1, {(W-1){1'b0}}};
  localparam logic [SW-1:0] Half    = SW'(1) << (F - 1);
  localparam logic [NW:0]   PosLim  = (NW+1)'(MaxVal);
  localparam logic [NW:0]   NegLim  = (NW+1)'(MinVal);
  localparam logic [NW:0]   NormLim = (NW+1)'(1) << (F + 2);

  typedef struct packed {
    op_e                  op;
    logic [3:0][W-1:0]    a;
    logic [3:0][W-1:0]    er;
    logic                 ef;
  } early_t;

  typedef struct packed {
    op_e                  op;
    logic [3:0][W-1:0]    a;
    logic [3:0][W-1:0]    res;
    logic                 flag;
    logic                 zero;
    logic [QW-1:0]        sq;
  } carry_t;

  typedef struct packed {
    carry_t               c;
    logic [2*RootW-1:0]   s;
    logic [RemW-1:0]      rem;
    logic [RootW-1:0]     root;
  } sqs_t;

  typedef struct packed {
    carry_t               c;
    logic [RootW-1:0]     mag;
  } rnd_t;

  typedef struct packed {
    carry_t               c;
    logic [3:0]           neg;
  } dly_t;

  function automatic logic [W:0] sat_ext(logic [W:0] v);
    logic [W:0] r;
    if (v[W] != v[W-1]) begin
      r = {1'b1, (v[W] ? MinVal : MaxVal)};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  logic pipe_en;

  assign pipe_en    = ~out_valid_o | out_ready_i;
  assign in_ready_o = pipe_en;

  // Stage 0: request register.
  qalu_req_t req0_q;
  logic      v0_q;
  op_e       op0;
  logic signed [W-1:0] qa0 [4];
  logic signed [W-1:0] qb0 [4];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      req0_q <= in_req_i;
    end
  end

  assign op0    = op_e'(req0_q.opcode);
  assign qa0[0] = req0_q.a_w;
  assign qa0[1] = req0_q.a_x;
  assign qa0[2] = req0_q.a_y;
  assign qa0[3] = req0_q.a_z;
  assign qb0[0] = req0_q.b_w;
  assign qb0[1] = req0_q.b_x;
  assign qb0[2] = req0_q.b_y;
  assign qb0[3] = req0_q.b_z;

  // Stage 1: sixteen multipliers. The normalize, inverse and magnitude opcodes put the four squares on lane 0.
  logic signed [W-1:0]  ml [4][4];
  logic signed [W-1:0]  mr [4][4];
  logic signed [PW-1:0] prod1_q [4][4];
  early_t               early_d, early1_q;
  logic                 v1_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        ml[k][j] = '0;
        mr[k][j] = '0;
        case (op0)
          OP_MUL: begin
            ml[k][j] = qa0[MulAIdx[k][j]];
            mr[k][j] = qb0[MulBIdx[k][j]];
          end
          OP_SCALE: begin
            if (j == 0) begin
              ml[k][j] = qa0[k];
              mr[k][j] = req0_q.scale_factor;
            end
          end
          OP_NORM, OP_INV, OP_MAG, OP_MAG2: begin
            if (k == 0) begin
              ml[k][j] = qa0[j];
              mr[k][j] = qa0[j];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    logic [W:0] t;
    early_d = '0;
    early_d.op = op0;
    for (int i = 0; i < 4; i++) begin
      early_d.a[i] = qa0[i];
      case (op0)
        OP_ADD:  t = sat_ext({qa0[i][W-1], qa0[i]} + {qb0[i][W-1], qb0[i]});
        OP_SUB:  t = sat_ext({qa0[i][W-1], qa0[i]} - {qb0[i][W-1], qb0[i]});
        OP_CONJ: t = (i == 0) ? {1'b0, qa0[i]} : sat_ext(-{qa0[i][W-1], qa0[i]});
        default: t = '0;
      endcase
      early_d.er[i] = t[W-1:0];
      early_d.ef    = early_d.ef | t[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 4; j++) begin
          prod1_q[k][j] <= ml[k][j] * mr[k][j];
        end
      end
      early1_q <= early_d;
    end
  end

  // Stage 2: signed pair sums.
  logic signed [PW:0] u2_d [4][2];
  logic signed [PW:0] u2_q [4][2];
  early_t             early2_q;
  logic               v2_q;

  always_comb begin
    logic signed [PW:0] e0;
    logic signed [PW:0] e1;
    for (int k = 0; k < 4; k++) begin
      for (int h = 0; h < 2; h++) begin
        e0 = $signed({prod1_q[k][2*h][PW-1], prod1_q[k][2*h]});
        e1 = $signed({prod1_q[k][2*h+1][PW-1], prod1_q[k][2*h+1]});
        if (early1_q.op == OP_MUL && MulNeg[k][2*h]) begin
          e0 = -e0;
        end
        if (early1_q.op == OP_MUL && MulNeg[k][2*h+1]) begin
          e1 = -e1;
        end
        u2_d[k][h] = e0 + e1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      u2_q     <= u2_d;
      early2_q <= early1_q;
    end
  end

  // Stage 3: full sums.
  logic signed [SW-1:0] v3_q [4];
  early_t               early3_q;
  logic                 v3v_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int k = 0; k < 4; k++) begin
        v3_q[k] <= $signed({u2_q[k][0][PW], u2_q[k][0]}) +
                   $signed({u2_q[k][1][PW], u2_q[k][1]});
      end
      early3_q <= early2_q;
    end
  end

  // Stage 4: round, saturate, and pick the result of the direct opcodes.
  carry_t c4;

  always_comb begin
    logic signed [SW-1:0] rs;
    logic signed [SW-1:0] sh;
    logic                 ok;
    logic [W-1:0]         rr [4];
    logic [3:0]           rf;
    for (int k = 0; k < 4; k++) begin
      rs    = v3_q[k] + $signed(Half);
      sh    = rs >>> F;
      ok    = (&sh[SW-1:W-1]) | ~(|sh[SW-1:W-1]);
      rr[k] = ok ? sh[W-1:0] : (sh[SW-1] ? MinVal : MaxVal);
      rf[k] = ~ok;
    end
    c4      = '0;
    c4.op   = early3_q.op;
    c4.a    = early3_q.a;
    c4.sq   = v3_q[0][QW-1:0];
    c4.zero = (v3_q[0][QW-1:0] == '0);
    case (early3_q.op)
      OP_ADD, OP_SUB, OP_CONJ: begin
        c4.res  = early3_q.er;
        c4.flag = early3_q.ef;
      end
      OP_MUL, OP_SCALE: begin
        for (int k = 0; k < 4; k++) begin
          c4.res[k] = rr[k];
        end
        c4.flag = |rf;
      end
      OP_MAG2: begin
        c4.res[0] = rr[0];
        c4.flag   = rf[0];
      end
      default: begin
      end
    endcase
  end

  // Square root, one root bit per stage; stage 0 is the stage 4 register.
  sqs_t             sqs_q [RootW+1];
  logic [RootW:0]   sqv_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sqs_q[0].c    <= c4;
      sqs_q[0].s    <= (2*RootW)'(c4.sq);
      sqs_q[0].rem  <= '0;
      sqs_q[0].root <= '0;
    end
  end

  for (genvar j = 0; j < RootW; j++) begin : g_sqrt
    logic [RemW-1:0] rem2;
    logic [RemW-1:0] trial;
    logic [RemW-1:0] diff;
    logic            ge;

    assign rem2  = {sqs_q[j].rem[RemW-3:0], sqs_q[j].s[2*RootW-1 -: 2]};
    assign trial = RemW'({sqs_q[j].root, 2'b01});
    assign ge    = rem2 >= trial;
    assign diff  = rem2 - trial;

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        sqs_q[j+1].c    <= sqs_q[j].c;
        sqs_q[j+1].s    <= sqs_q[j].s << 2;
        sqs_q[j+1].rem  <= ge ? diff : rem2;
        sqs_q[j+1].root <= {sqs_q[j].root[RootW-2:0], ge};
      end
    end
  end

  // Round the root to nearest and finish the magnitude opcode.
  rnd_t rnd_d, rnd_q;
  logic rndv_q;

  always_comb begin
    logic rnd_up;
    logic over;
    rnd_d     = '0;
    rnd_d.c   = sqs_q[RootW].c;
    rnd_up    = sqs_q[RootW].rem > RemW'(sqs_q[RootW].root);
    rnd_d.mag = sqs_q[RootW].root + RootW'(rnd_up);
    over      = |rnd_d.mag[RootW-1:W-1];
    if (sqs_q[RootW].c.op == OP_MAG) begin
      rnd_d.c.res[0] = over ? MaxVal : rnd_d.mag[W-1:0];
      rnd_d.c.flag   = over;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      rnd_q <= rnd_d;
    end
  end

  // Dividers: normalize divides by the magnitude, inverse by the squared norm.
  logic [NW-1:0] num [4];
  logic [QW-1:0] den;
  logic [NW:0]   quo [4];
  dly_t          dly_d;
  dly_t          dly_q [DivLat];
  logic [DivLat-1:0] dlyv_q;

  always_comb begin
    logic [W-1:0] ua;
    logic         is_inv;
    is_inv  = (rnd_q.c.op == OP_INV);
    den     = is_inv ? rnd_q.c.sq : QW'(rnd_q.mag);
    dly_d   = '0;
    dly_d.c = rnd_q.c;
    for (int i = 0; i < 4; i++) begin
      ua     = rnd_q.c.a[i][W-1] ? (~rnd_q.c.a[i] + W'(1)) : rnd_q.c.a[i];
      num[i] = is_inv ? (NW'(ua) << (2 * F)) : (NW'(ua) << F);
      dly_d.neg[i] = rnd_q.c.a[i][W-1] ^ (is_inv && (i != 0));
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_div
    qalu_div #(
      .NumW (NW),
      .DenW (QW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .num_i (num[i]),
      .den_i (den),
      .quo_o (quo[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dly_q[0] <= dly_d;
      for (int j = 1; j < DivLat; j++) begin
        dly_q[j] <= dly_q[j-1];
      end
    end
  end

  // Output stage: sign, saturate and merge the divider results.
  qalu_rsp_t out_d, out_q;
  logic      outv_q;
  dly_t      dl;

  assign dl = dly_q[DivLat-1];

  always_comb begin
    logic [W-1:0] dv [4];
    logic [3:0]   df;
    logic [W-1:0] rv [4];
    logic         fl;
    for (int i = 0; i < 4; i++) begin
      if (dl.neg[i]) begin
        df[i] = quo[i] > NegLim;
        dv[i] = df[i] ? MinVal : (~quo[i][W-1:0] + W'(1));
      end else begin
        df[i] = quo[i] > PosLim;
        dv[i] = df[i] ? MaxVal : quo[i][W-1:0];
      end
      rv[i] = dl.c.res[i];
    end
    fl = dl.c.flag;
    case (dl.c.op)
      OP_NORM: begin
        for (int i = 0; i < 4; i++) begin
          rv[i] = dl.c.zero ? dl.c.a[i] : dv[i];
        end
        fl = dl.c.zero ? 1'b0 : (|df);
      end
      OP_INV: begin
        for (int i = 0; i < 4; i++) begin
          rv[i] = dl.c.zero ? '0 : dv[i];
        end
        fl = dl.c.zero ? 1'b1 : (|df);
      end
      default: begin
      end
    endcase
    out_d.r_w        = rv[0];
    out_d.r_x        = rv[1];
    out_d.r_y        = rv[2];
    out_d.r_z        = rv[3];
    out_d.range_flag = fl;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3v_q  <= 1'b0;
      sqv_q  <= '0;
      rndv_q <= 1'b0;
      dlyv_q <= '0;
      outv_q <= 1'b0;
    end else if (pipe_en) begin
      v0_q   <= in_valid_i;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      v3v_q  <= v2_q;
      sqv_q  <= {sqv_q[RootW-1:0], v3v_q};
      rndv_q <= sqv_q[RootW];
      dlyv_q <= {dlyv_q[DivLat-2:0], rndv_q};
      outv_q <= dlyv_q[DivLat-1];
    end
  end

  assign out_valid_o = outv_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTH
  // The square root remainder never exceeds twice the partial root.
  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqv_q[RootW] |-> (sqs_q[RootW].rem <= RemW'({sqs_q[RootW].root, 1'b0})))
    else $error("square root remainder out of bound");

  // A normalized component does not exceed four.
  a_norm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dlyv_q[DivLat-1] && dl.c.op == OP_NORM && !dl.c.zero) |->
      (quo[0] <= NormLim && quo[1] <= NormLim && quo[2] <= NormLim && quo[3] <= NormLim))
    else $error("normalize quotient too large");

  // Inverting a zero quaternion always raises the range flag.
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_en && dlyv_q[DivLat-1] && dl.c.op == OP_INV && dl.c.zero) |=>
      (out_valid_o && out_rsp_o.range_flag))
    else $error("inverse of zero did not raise the flag");
`endif

endmodule
